// ===== hdl/mexp_pkg.sv =====
// Shared types and constants for the modular exponentiation unit.
`default_nettype none

package mexp_pkg;

   localparam int WORD_BITS    = 31;
   localparam int PROD_BITS    = 2 * WORD_BITS;
   localparam int RED_CNT_BITS = $clog2(PROD_BITS + 1);
   localparam int EXP_CNT_BITS = $clog2(WORD_BITS + 1);

   typedef logic [WORD_BITS-1:0] word_type;

   localparam word_type WORD_ONE = word_type'(1);

   // Request to the shared multiply-and-reduce unit.
   typedef struct packed {
      logic     start;
      word_type op_a;
      word_type op_b;
   } mm_req_type;

   // Answer from the shared multiply-and-reduce unit.
   typedef struct packed {
      logic     done;
      word_type result;
   } mm_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_SQUARE,
      ST_SQ_WAIT,
      ST_MULT,
      ST_MUL_WAIT,
      ST_NEXT,
      ST_DONE
   } seq_state_type;

endpackage

`default_nettype wire

// ===== hdl/mexp_modmul.sv =====
// Shared modular multiplier: one registered product, then bit-serial restoring reduction.
`default_nettype none

module mexp_modmul
   import mexp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire word_type   modulus,
   input  wire mm_req_type req,
   output mm_rsp_type      rsp
);

   logic                    active_ff, active_in;
   logic                    done_ff, done_in;
   logic [RED_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [PROD_BITS-1:0]    prod_ff, prod_in;
   word_type                rem_ff, rem_in;
   logic [WORD_BITS:0]      shifted;
   logic [WORD_BITS:0]      wide_mod;

   assign wide_mod = {1'b0, modulus};
   // The remainder stays below the modulus, so the reduced value always fits back in a word.
   assign shifted  = {rem_ff, prod_ff[PROD_BITS-1]};

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      prod_in   = prod_ff;
      rem_in    = rem_ff;
      if (req.start) begin
         active_in = 1'b1;
         cnt_in    = RED_CNT_BITS'(PROD_BITS);
         prod_in   = PROD_BITS'(req.op_a) * PROD_BITS'(req.op_b);
         rem_in    = '0;
      end else if (active_ff) begin
         prod_in = {prod_ff[PROD_BITS-2:0], 1'b0};
         rem_in  = (shifted >= wide_mod) ? word_type'(shifted - wide_mod)
                                         : word_type'(shifted);
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == RED_CNT_BITS'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
   end

   // A zero modulus reduces everything to zero.
   assign rsp.done   = done_ff;
   assign rsp.result = (modulus == '0) ? '0 : rem_ff;

endmodule

`default_nettype wire

// ===== hdl/mexp_seq.sv =====
// Square-and-multiply sequencer that drives the shared modular multiplier.
`default_nettype none

module mexp_seq
   import mexp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire word_type   base,
   input  wire word_type   exponent,
   output logic            busy,
   output logic            rsp_strobe,
   output word_type        rsp_power_mod,
   output mm_req_type      mm_req,
   input  wire mm_rsp_type mm_rsp
);

   seq_state_type           state_ff, state_in;
   word_type                exp_ff;
   word_type                base_ff;
   word_type                acc_ff;
   logic [EXP_CNT_BITS-1:0] bits_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_FIND;
         end
         ST_FIND: begin
            if (exp_ff == '0) state_in = ST_DONE;
            else if (exp_ff[WORD_BITS-1]) state_in = ST_SQUARE;
         end
         ST_SQUARE: state_in = ST_SQ_WAIT;
         ST_SQ_WAIT: begin
            if (mm_rsp.done) state_in = exp_ff[WORD_BITS-1] ? ST_MULT : ST_NEXT;
         end
         ST_MULT: state_in = ST_MUL_WAIT;
         ST_MUL_WAIT: begin
            if (mm_rsp.done) state_in = ST_NEXT;
         end
         ST_NEXT: begin
            state_in = (bits_ff == EXP_CNT_BITS'(1)) ? ST_DONE : ST_SQUARE;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy          = (state_ff != ST_IDLE);
      rsp_strobe    = (state_ff == ST_DONE);
      rsp_power_mod = acc_ff;
      mm_req.start  = 1'b0;
      mm_req.op_a   = acc_ff;
      mm_req.op_b   = acc_ff;
      case (state_ff)
         ST_SQUARE: mm_req.start = 1'b1;
         ST_MULT: begin
            mm_req.start = 1'b1;
            mm_req.op_a  = base_ff;
         end
         default: mm_req.start = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            exp_ff  <= exponent;
            base_ff <= base;
            acc_ff  <= WORD_ONE;
            bits_ff <= EXP_CNT_BITS'(WORD_BITS);
         end
         ST_FIND: begin
            if (exp_ff != '0 && !exp_ff[WORD_BITS-1]) begin
               exp_ff  <= {exp_ff[WORD_BITS-2:0], 1'b0};
               bits_ff <= bits_ff - 1'b1;
            end
         end
         ST_SQ_WAIT, ST_MUL_WAIT: begin
            if (mm_rsp.done) acc_ff <= mm_rsp.result;
         end
         ST_NEXT: begin
            exp_ff  <= {exp_ff[WORD_BITS-2:0], 1'b0};
            bits_ff <= bits_ff - 1'b1;
         end
         default: acc_ff <= acc_ff;
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/modular_exponentiation_unit.sv =====
// Top level of the modular exponentiation unit.
`default_nettype none

// Raises a base to an exponent modulo a configured modulus, by square-and-multiply.
//
// Input channel: a beat of req_base and req_exponent is taken at a rising edge with
// start high and busy low. Busy then stays high until the result has been given.
// Result channel: rsp_power_mod is shown for exactly one cycle with rsp_strobe high;
// the receiver cannot stall it, so it must take the beat in that cycle.
// Configuration: csr_modulus is written on a csr_valid beat (csr_ready is always
// high). It should only be written while busy is low.
//
// Sequence: leading zero bits of the exponent are skipped first, one at a time. Each
// remaining bit costs one modular square, plus one modular multiply when it is set.
// Each goes through the one shared multiplier: the full-width product is registered,
// then reduced by one-bit restoring steps over every product bit, and handed over.
// Stepping to the next bit is a state of its own. The block takes no new item until
// its result has been given.
//
// Reset is synchronous: the sequencer returns to idle, no result is pending and the
// modulus register returns to 1.

module modular_exponentiation_unit
   import mexp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [WORD_BITS-1:0] req_base,
   input  wire logic [WORD_BITS-1:0] req_exponent,
   output logic                      rsp_strobe,
   output logic [WORD_BITS-1:0]      rsp_power_mod,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [WORD_BITS-1:0] csr_modulus
);

   word_type   modulus_ff, modulus_in;
   mm_req_type mm_req;
   mm_rsp_type mm_rsp;

   // The register is always able to take a beat.
   assign csr_ready  = 1'b1;
   assign modulus_in = (csr_valid && csr_ready) ? csr_modulus : modulus_ff;

   always_ff @(posedge clock) begin
      if (reset) modulus_ff <= WORD_ONE;
      else modulus_ff <= modulus_in;
   end

   // The sequencer walks the exponent from its top set bit downwards.
   mexp_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .base          (req_base),
      .exponent      (req_exponent),
      .busy          (busy),
      .rsp_strobe    (rsp_strobe),
      .rsp_power_mod (rsp_power_mod),
      .mm_req        (mm_req),
      .mm_rsp        (mm_rsp)
   );

   // One multiplier and one subtractor serve every square and every multiply.
   mexp_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .modulus (modulus_ff),
      .req     (mm_req),
      .rsp     (mm_rsp)
   );

endmodule

`default_nettype wire

// ===== hdl/mexp_checker.sv =====
// Port-level checks on the modular exponentiation unit, bound to the top level.
`default_nettype none

module mexp_checker
   import mexp_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 start,
   input wire logic                 busy,
   input wire logic                 rsp_strobe,
   input wire logic [WORD_BITS-1:0] rsp_power_mod
);

   // An accepted beat always makes the block busy.
   a_start_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   // A result comes only while an item is in progress.
   a_strobe_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   // The result beat ends the item: the block is free in the next cycle.
   a_strobe_frees : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!busy && !rsp_strobe))
      else $error("block still busy after its result");

   // Results always fit below the top of the word range.
   a_result_range : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_power_mod != {WORD_BITS{1'b1}}))
      else $error("result out of range");

endmodule

bind modular_exponentiation_unit mexp_checker u_mexp_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_power_mod (rsp_power_mod)
);

`default_nettype wire

// ===== test/tb_modular_exponentiation_unit.sv =====
// Self-checking testbench for the modular exponentiation unit, with its own square-and-multiply predictor.
`timescale 1ns / 100ps

module tb_modular_exponentiation_unit
   import mexp_pkg::*;
();

   // The largest value a word can hold, which is also the top of the modulus range.
   localparam word_type WORD_MAX = {WORD_BITS{1'b1}};

   // The wait after the last expected beat, so that a stray late result is
   // still caught.
   localparam int SETTLE_CYCLES = 4200;

   // A bound on the final drain, so that a lost result cannot hang the run.
   localparam int DRAIN_LIMIT = 20000;

   // Number of random items in each of the three idling phases.
   localparam int RANDOM_PER_PHASE = 39;

   logic     clock        = 1'b0;
   logic     reset        = 1'b1;
   logic     start        = 1'b0;
   logic     busy;
   word_type req_base     = '0;
   word_type req_exponent = '0;
   logic     rsp_strobe;
   word_type rsp_power_mod;
   logic     csr_valid    = 1'b0;
   logic     csr_ready;
   word_type csr_modulus  = '0;

   // Our own copy of the modulus register. It follows every accepted write beat.
   word_type current_modulus = WORD_ONE;

   // Expected results, oldest first. A beat is added when the block accepts it.
   word_type expected_powers[$];

   int mismatch_count  = 0;

   // Chance in a hundred that the sender idles before its next beat; the same chance is drawn again to keep it idling.
   int sender_idle_pct = 0;

   modular_exponentiation_unit DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_base      (req_base),
      .req_exponent  (req_exponent),
      .rsp_strobe    (rsp_strobe),
      .rsp_power_mod (rsp_power_mod),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_modulus   (csr_modulus)
   );

   // A 10 ns clock: high for half the period, then low for half.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The run is ended here if the block stops answering.
   initial begin
      #40_000_000;
      $display("FAIL");
      $finish;
   end

   // Square-and-multiply over the exponent, from its highest set bit down to
   // bit 0. Every product is formed at 64 bits, so nothing overflows. A modulus
   // of zero turns every reduction into zero, and an exponent of zero leaves
   // the running value at one, without any reduction.
   function automatic word_type predict_power_mod(input word_type base,
                                                  input word_type exponent,
                                                  input word_type modulus);
      longint unsigned acc;
      int              top;
      acc = 1;
      top = -1;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (exponent[i]) top = i;
      end
      for (int i = top; i >= 0; i--) begin
         acc = (modulus == '0) ? 0 : (acc * acc) % longint'(modulus);
         if (exponent[i]) begin
            acc = (modulus == '0) ? 0 :
                  (longint'(base) * acc) % longint'(modulus);
         end
      end
      return word_type'(acc);
   endfunction

   task automatic report_mismatch(input string what, input word_type got,
                                  input word_type want);
      $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // Every result beat is taken in the cycle that it is shown, since the block
   // cannot be held off. Values read here are those from before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_powers.size() == 0) begin
            report_mismatch("unexpected result beat", rsp_power_mod, '0);
         end else if (rsp_power_mod !== expected_powers[0]) begin
            report_mismatch("power_mod", rsp_power_mod, expected_powers[0]);
            void'(expected_powers.pop_front());
         end else begin
            void'(expected_powers.pop_front());
         end
      end
   end

   // Sends one request beat and records what it should produce. Start stays high
   // on return, so that a following beat can go out back to back; it is lowered
   // only when the sender really idles.
   task automatic send_item(input word_type base, input word_type exponent);
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      start        <= 1'b1;
      req_base     <= base;
      req_exponent <= exponent;
      do @(posedge clock); while (busy);
      expected_powers = {expected_powers,
                         predict_power_mod(base, exponent, current_modulus)};
   endtask

   // Holds the sender back until every expected result has come in and the
   // block has dropped busy.
   task automatic wait_for_idle();
      start <= 1'b0;
      while (expected_powers.size() != 0) @(posedge clock);
      do @(posedge clock); while (busy);
   endtask

   // The modulus is only written while the block is idle.
   task automatic write_modulus(input word_type value);
      wait_for_idle();
      csr_valid   <= 1'b1;
      csr_modulus <= value;
      do @(posedge clock); while (!csr_ready);
      current_modulus = value;
      csr_valid <= 1'b0;
   endtask

   // Exponents are mostly short, so that the run stays quick; now and then one
   // spans the whole word.
   function automatic word_type random_exponent();
      int bits;
      if ($urandom_range(9) == 0) return word_type'($urandom);
      bits = $urandom_range(12);
      return word_type'($urandom) & ((word_type'(1) << bits) - WORD_ONE);
   endfunction

   // Bases are mostly anything at all, sometimes tiny, and sometimes right at
   // the modulus, where the unreduced base matters most.
   function automatic word_type random_base();
      case ($urandom_range(9))
         0, 1:    return word_type'($urandom_range(15));
         2:       return current_modulus - WORD_ONE;
         3:       return current_modulus;
         4:       return current_modulus + WORD_ONE;
         default: return word_type'($urandom);
      endcase
   endfunction

   // The modulus is still at its reset value of one: a zero exponent answers
   // one with no reduction, while anything else reduces to zero.
   task automatic test_reset_modulus();
      send_item(word_type'(12345), '0);
      send_item(WORD_MAX, '0);
      send_item(word_type'(7), word_type'(5));
      send_item(WORD_MAX, WORD_MAX);
   endtask

   // Field extremes against the largest modulus, which is also a prime.
   task automatic test_field_extremes();
      write_modulus(WORD_MAX);
      send_item('0, '0);
      send_item('0, WORD_MAX);
      send_item(WORD_MAX, word_type'(1));
      send_item(WORD_MAX - WORD_ONE, WORD_MAX);
      send_item(word_type'(2), word_type'(30));
      send_item(word_type'(3), word_type'(1) << (WORD_BITS - 1));
      send_item(word_type'(2), word_type'(31));
      send_item(WORD_ONE, WORD_MAX);
   endtask

   // A base well above a small modulus is not reduced on entry, yet the answer
   // must still come out right.
   task automatic test_base_above_modulus();
      write_modulus(word_type'(1000003));
      send_item(WORD_MAX, word_type'(1));
      send_item(WORD_MAX, word_type'(2));
      send_item(word_type'(2000006), word_type'(77));
      send_item(word_type'(1000004), WORD_MAX);
   endtask

   // A modulus of zero lies outside the working range: every reduction gives
   // zero, and only a zero exponent still answers one.
   task automatic test_zero_modulus();
      write_modulus('0);
      send_item(word_type'(9), '0);
      send_item(word_type'(9), word_type'(7));
      send_item(WORD_MAX, WORD_MAX);
   endtask

   // Modulus one, this time written explicitly, followed by the smallest
   // modulus under which a reduced result can be nonzero.
   task automatic test_small_moduli();
      write_modulus(WORD_ONE);
      send_item(word_type'(5), '0);
      send_item(word_type'(5), word_type'(3));
      write_modulus(word_type'(2));
      send_item(word_type'(3), word_type'(1000));
      send_item(word_type'(4), word_type'(1));
   endtask

   // Random traffic in three phases: a sender that rarely idles, one that idles
   // most of the time, and one that never does. Each phase runs under a fresh
   // modulus, and the middle one also pauses until the block has drained.
   task automatic test_random_traffic();
      int idle_pcts[3];
      idle_pcts = '{10, 80, 0};
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0:       write_modulus(word_type'($urandom_range(32'h7FFF_FFFF, 32'h4000_0000)));
            1:       write_modulus(word_type'($urandom_range(5000, 2)));
            default: write_modulus(word_type'($urandom_range(32'h7FFF_FFFF, 1)));
         endcase
         sender_idle_pct = idle_pcts[phase];
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (phase == 1 && n == RANDOM_PER_PHASE / 2) wait_for_idle();
            send_item(random_base(), random_exponent());
         end
      end
      sender_idle_pct = 0;
   endtask

   initial begin
      int waited;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_modulus();
      test_field_extremes();
      test_base_above_modulus();
      test_zero_modulus();
      test_small_moduli();
      test_random_traffic();

      // Every beat has gone out; let the remaining results arrive, then keep
      // watching long enough for one more item's worth of latency.
      start <= 1'b0;
      waited = 0;
      while (expected_powers.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (expected_powers.size() != 0) begin
         report_mismatch("missing result beat", '0, expected_powers.pop_front());
      end

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
